### rtl/ytc_pkg.sv
// Shared types and constants for the Young tableau counter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ytc_pkg;

    localparam int NUM_ROWS = 5;
    localparam int IN_W     = 3;
    localparam int COUNT_W  = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_FINISH
    } ytc_state_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic calc;
        logic publish;
    } ytc_cmd_t;

    typedef struct packed {
        logic last_cell;
        logic out_full;
        logic out_take;
    } ytc_status_t;

endpackage

`default_nettype wire

### rtl/ytc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing; holds the counting table in the datapath.
`default_nettype none

module ytc_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

### rtl/ytc_ctrl.sv
// Sequencer for the Young tableau counter: input handshake and per-cell steps.
// Depends on ytc_pkg; drives the datapath through ytc_cmd_t.
`default_nettype none

module ytc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire ytc_pkg::ytc_status_t status,
    output ytc_pkg::ytc_cmd_t         cmd
);

    import ytc_pkg::*;

    ytc_state_t state_reg;
    ytc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = status.last_cell ? ST_FINISH : ST_READ;
            end
            ST_FINISH:
            begin
                if (!status.out_full || status.out_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall  = 1'b1;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            ST_READ:
            begin
                cmd = '0;
            end
            ST_CALC:
            begin
                cmd.calc    = 1'b1;
                cmd.advance = !status.last_cell;
            end
            ST_FINISH:
            begin
                cmd.publish = !status.out_full || status.out_take;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ytc_datapath.sv
// Datapath of the Young tableau counter: lengths, cell counters, table RAMs,
// saturating sum of predecessors and the result register. Depends on ytc_pkg, ytc_ram.
`default_nettype none

module ytc_datapath #(
    parameter int MAX_ROW_LEN = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ytc_pkg::ytc_cmd_t           cmd,
    output ytc_pkg::ytc_status_t             status,
    input  wire logic [ytc_pkg::IN_W-1:0]    num_rows,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_one_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_two_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_three_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_four_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_five_len,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic      [ytc_pkg::COUNT_W-1:0] tableau_count,
    output logic                             count_overflow
);

    import ytc_pkg::*;

    localparam int CW    = $clog2(MAX_ROW_LEN + 1);
    localparam int LW    = (CW > IN_W) ? CW : IN_W;
    localparam int AW    = NUM_ROWS * CW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = COUNT_W + 1;
    localparam int SUM_W = COUNT_W + 3;

    logic [CW-1:0]     len_reg  [NUM_ROWS];
    logic [CW-1:0]     len_next [NUM_ROWS];
    logic [CW-1:0]     pos_reg  [NUM_ROWS];
    logic [CW-1:0]     pos_next [NUM_ROWS];
    logic [IN_W-1:0]   raw_len  [NUM_ROWS];
    logic [LW-1:0]     raw_ext  [NUM_ROWS];
    logic              carry;
    logic              at_origin;
    logic              at_end;
    logic              in_box;

    logic [AW-1:0]     here_addr;
    logic [AW-1:0]     pred_addr [NUM_ROWS-1];
    logic              pred_ok   [NUM_ROWS];
    logic [DW-1:0]     pred_data [NUM_ROWS];
    logic [DW-1:0]     prev_reg;

    logic [SUM_W-1:0]  sum;
    logic              ovf_in;
    logic              cell_ovf;
    logic [COUNT_W-1:0] cell_count;

    logic               result_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;
    logic               out_take;

    // Clamp each length and zero rows beyond the row count.
    always_comb
    begin
        raw_len[0] = row_one_len;
        raw_len[1] = row_two_len;
        raw_len[2] = row_three_len;
        raw_len[3] = row_four_len;
        raw_len[4] = row_five_len;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            raw_ext[i] = LW'(raw_len[i]);
            if (raw_ext[i] > LW'(MAX_ROW_LEN))
            begin
                raw_ext[i] = LW'(MAX_ROW_LEN);
            end
            len_next[i] = (IN_W'(i) < num_rows) ? CW'(raw_ext[i]) : '0;
        end
    end

    // Lexicographic step, last row innermost.
    always_comb
    begin
        carry = 1'b1;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            pos_next[i] = pos_reg[i];
        end
        for (int i = NUM_ROWS - 1; i >= 0; i--)
        begin
            if (carry)
            begin
                if (pos_reg[i] == len_reg[i])
                begin
                    pos_next[i] = '0;
                end
                else
                begin
                    pos_next[i] = pos_reg[i] + CW'(1);
                    carry       = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        at_origin = 1'b1;
        at_end    = 1'b1;
        in_box    = 1'b1;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            at_origin = at_origin && (pos_reg[i] == '0);
            at_end    = at_end && (pos_reg[i] == len_reg[i]);
            in_box    = in_box && (pos_reg[i] <= len_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                len_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                len_reg[i] <= len_next[i];
                pos_reg[i] <= '0;
            end
        end
        else if (cmd.advance)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                pos_reg[i] <= pos_next[i];
            end
        end
    end

    // Table address: row one in the top field. A predecessor has one field one lower.
    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            here_addr[(NUM_ROWS - 1 - i) * CW +: CW] = pos_reg[i];
        end
        for (int k = 0; k < NUM_ROWS - 1; k++)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                pred_addr[k][(NUM_ROWS - 1 - i) * CW +: CW] =
                    (i == k) ? pos_reg[i] - CW'(1) : pos_reg[i];
            end
        end
        pred_ok[0] = (pos_reg[0] != '0);
        for (int k = 1; k < NUM_ROWS; k++)
        begin
            pred_ok[k] = (pos_reg[k] != '0) && (pos_reg[k] <= pos_reg[k - 1]);
        end
    end

    // Two copies of the table give four predecessor reads per cell.
    ytc_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_tbl_hi (
        .clk       (clk),
        .wr_en     (cmd.calc),
        .wr_addr   (here_addr),
        .wr_data   ({cell_ovf, cell_count}),
        .rd_addr_a (pred_addr[0]),
        .rd_addr_b (pred_addr[1]),
        .rd_data_a (pred_data[0]),
        .rd_data_b (pred_data[1])
    );

    ytc_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_tbl_lo (
        .clk       (clk),
        .wr_en     (cmd.calc),
        .wr_addr   (here_addr),
        .wr_data   ({cell_ovf, cell_count}),
        .rd_addr_a (pred_addr[2]),
        .rd_addr_b (pred_addr[3]),
        .rd_data_a (pred_data[2]),
        .rd_data_b (pred_data[3])
    );

    // The last-row predecessor is the cell computed just before this one.
    assign pred_data[NUM_ROWS - 1] = prev_reg;

    // Full-width sum of the predecessors; saturate once at the end.
    always_comb
    begin
        sum    = SUM_W'(at_origin);
        ovf_in = 1'b0;
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            if (pred_ok[k])
            begin
                sum    = sum + SUM_W'(pred_data[k][COUNT_W-1:0]);
                ovf_in = ovf_in | pred_data[k][COUNT_W];
            end
        end
        cell_ovf   = ovf_in || (sum[SUM_W-1:COUNT_W] != '0);
        cell_count = (sum[SUM_W-1:COUNT_W] != '0) ? '1 : sum[COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            prev_reg <= {cell_ovf, cell_count};
        end
        if (cmd.publish)
        begin
            count_reg <= prev_reg[COUNT_W-1:0];
            ovf_reg   <= prev_reg[COUNT_W];
        end
    end

    assign out_take = result_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid     = result_valid_reg;
    assign tableau_count    = count_reg;
    assign count_overflow   = ovf_reg;
    assign status.last_cell = at_end;
    assign status.out_full  = result_valid_reg;
    assign status.out_take  = out_take;

    a_load_origin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> at_origin)
        else $error("cell counters not at origin after load");

    a_calc_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |-> in_box)
        else $error("cell counters outside the shape");

    a_seed_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.calc && at_origin) |-> (cell_count == COUNT_W'(1) && !cell_ovf))
        else $error("empty cell does not count one");

    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> result_valid_reg)
        else $error("result not presented after publish");

endmodule

`default_nettype wire

### rtl/young_tableau_counter_top.sv
// Young tableau counter: counts the standard Young tableaux of a shape of up to
// five rows. Each accepted item is processed cell by cell on the table RAM:
// a read state fetches the predecessors, then a calc state sums them,
// saturates and writes back; a finish state then publishes the result, after
// which the next transaction can be accepted. The table is two RAM copies of
// 2^(5*ceil(log2(MAX_ROW_LEN+1))) x 65 bits with two read ports each; every
// cell is written before it is read, so there is no clearing pass. A new
// transaction is accepted while the previous result still waits to be taken.
// Depends on ytc_pkg, ytc_ctrl, ytc_datapath.
`default_nettype none

module young_tableau_counter_top #(
    parameter int MAX_ROW_LEN = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [ytc_pkg::IN_W-1:0]    num_rows,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_one_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_two_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_three_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_four_len,
    input  wire logic [ytc_pkg::IN_W-1:0]    row_five_len,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic      [ytc_pkg::COUNT_W-1:0] tableau_count,
    output logic                             count_overflow
);

    import ytc_pkg::*;

    ytc_cmd_t    cmd;
    ytc_status_t status;

    ytc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ytc_datapath #(
        .MAX_ROW_LEN (MAX_ROW_LEN)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .num_rows       (num_rows),
        .row_one_len    (row_one_len),
        .row_two_len    (row_two_len),
        .row_three_len  (row_three_len),
        .row_four_len   (row_four_len),
        .row_five_len   (row_five_len),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .tableau_count  (tableau_count),
        .count_overflow (count_overflow)
    );

endmodule

`default_nettype wire
